// ----- rtl/mahd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahd_pkg - MPEG audio header decode shared definitions
// Transaction structs, queue entry and stage types, and the rate, bitrate
// and reciprocal tables used by the front section.
// ----------------------------------------------------------------------------
package mahd_pkg;

   // Header constants
   localparam logic [10:0] SYNC_PATTERN = 11'h7ff;
   localparam logic [1:0]  LCODE_RESERVED = 2'd0;
   localparam logic [1:0]  LCODE_LAYER1 = 2'd3;
   localparam logic [3:0]  BRI_FREE = 4'd0;
   localparam logic [3:0]  BRI_BAD = 4'd15;
   localparam logic [1:0]  RATE_RESERVED = 2'd3;
   localparam logic [1:0]  MODE_MONO = 2'd3;
   localparam logic [1:0]  LAYER_1 = 2'd1;
   localparam logic [1:0]  LAYER_2 = 2'd2;
   localparam logic [3:0]  FIDX_MAX = 4'd8;

   // Frame length multipliers (bit-rate in kbit/s times these over hz)
   localparam logic [17:0] MUL_LAYER1 = 18'd12000;
   localparam logic [17:0] MUL_SLOTS = 18'd144000;
   localparam logic [17:0] MUL_SLOTS_LSF = 18'd72000;

   // Reciprocal scale: floor(2^RECIP_SHIFT / hz), numerator below 2^RECIP_SHIFT
   localparam int RECIP_SHIFT = 26;
   localparam int NUMER_W = 26;
   localparam int RECIP_W = 14;
   localparam int QUOT_W = 12;

   typedef struct packed {
      logic [10:0] sync_word;
      logic        ext_flag;
      logic        version_id;
      logic [1:0]  layer_code;
      logic        crc_absent;
      logic [3:0]  bitrate_index;
      logic [1:0]  rate_index;
      logic        padding;
      logic [1:0]  channel_mode;
   } req_type;

   typedef struct packed {
      logic        header_valid;
      logic        decode_ok;
      logic [1:0]  layer_number;
      logic [11:0] payload_len;
      logic        low_rate_flag;
      logic        two_channels;
      logic [5:0]  side_info_bytes;
      logic [15:0] sample_rate_hz;
      logic [8:0]  bitrate_kbps;
      logic [3:0]  rate_table_index;
   } rsp_type;

   // Fields decoded by the front section, carried through the back pipeline
   typedef struct packed {
      logic        hdr_ok;
      logic [1:0]  layer;
      logic        lsf;
      logic        chan;
      logic [5:0]  side;
      logic [15:0] hz;
      logic [8:0]  br;
      logic [3:0]  fidx;
      logic        pad;
   } info_type;

   // Queue entry: decoded info plus divider operands
   typedef struct packed {
      info_type             info;
      logic [NUMER_W-1:0]   numer;
      logic [RECIP_W-1:0]   recip;
   } entry_type;

   // Bit-rate table lookup in kbit/s
   function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] layer,
                                              input logic [3:0] bri);
      logic [8:0] v;
      v = 9'd0;
      if (!lsf) begin
         case (layer)
            LAYER_1: begin
               case (bri)
                  4'd1: v = 9'd32;   4'd2: v = 9'd64;   4'd3: v = 9'd96;
                  4'd4: v = 9'd128;  4'd5: v = 9'd160;  4'd6: v = 9'd192;
                  4'd7: v = 9'd224;  4'd8: v = 9'd256;  4'd9: v = 9'd288;
                  4'd10: v = 9'd320; 4'd11: v = 9'd352; 4'd12: v = 9'd384;
                  4'd13: v = 9'd416; 4'd14: v = 9'd448;
                  default: v = 9'd0;
               endcase
            end
            LAYER_2: begin
               case (bri)
                  4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;
                  4'd4: v = 9'd64;   4'd5: v = 9'd80;   4'd6: v = 9'd96;
                  4'd7: v = 9'd112;  4'd8: v = 9'd128;  4'd9: v = 9'd160;
                  4'd10: v = 9'd192; 4'd11: v = 9'd224; 4'd12: v = 9'd256;
                  4'd13: v = 9'd320; 4'd14: v = 9'd384;
                  default: v = 9'd0;
               endcase
            end
            default: begin
               case (bri)
                  4'd1: v = 9'd32;   4'd2: v = 9'd40;   4'd3: v = 9'd48;
                  4'd4: v = 9'd56;   4'd5: v = 9'd64;   4'd6: v = 9'd80;
                  4'd7: v = 9'd96;   4'd8: v = 9'd112;  4'd9: v = 9'd128;
                  4'd10: v = 9'd160; 4'd11: v = 9'd192; 4'd12: v = 9'd224;
                  4'd13: v = 9'd256; 4'd14: v = 9'd320;
                  default: v = 9'd0;
               endcase
            end
         endcase
      end else if (layer == LAYER_1) begin
         case (bri)
            4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;
            4'd4: v = 9'd64;   4'd5: v = 9'd80;   4'd6: v = 9'd96;
            4'd7: v = 9'd112;  4'd8: v = 9'd128;  4'd9: v = 9'd144;
            4'd10: v = 9'd160; 4'd11: v = 9'd176; 4'd12: v = 9'd192;
            4'd13: v = 9'd224; 4'd14: v = 9'd256;
            default: v = 9'd0;
         endcase
      end else begin
         case (bri)
            4'd1: v = 9'd8;    4'd2: v = 9'd16;   4'd3: v = 9'd24;
            4'd4: v = 9'd32;   4'd5: v = 9'd40;   4'd6: v = 9'd48;
            4'd7: v = 9'd56;   4'd8: v = 9'd64;   4'd9: v = 9'd80;
            4'd10: v = 9'd96;  4'd11: v = 9'd112; 4'd12: v = 9'd128;
            4'd13: v = 9'd144; 4'd14: v = 9'd160;
            default: v = 9'd0;
         endcase
      end
      return v;
   endfunction

   // Sampling rate table in hertz
   function automatic logic [15:0] hz_lookup(input logic [3:0] fidx);
      logic [15:0] v;
      case (fidx)
         4'd0: v = 16'd44100;
         4'd1: v = 16'd48000;
         4'd2: v = 16'd32000;
         4'd3: v = 16'd22050;
         4'd4: v = 16'd24000;
         4'd5: v = 16'd16000;
         4'd6: v = 16'd11025;
         4'd7: v = 16'd12000;
         default: v = 16'd8000;
      endcase
      return v;
   endfunction

   // floor(2^26 / hz) for each table rate
   function automatic logic [RECIP_W-1:0] recip_lookup(input logic [3:0] fidx);
      logic [RECIP_W-1:0] v;
      case (fidx)
         4'd0: v = RECIP_W'(1521);
         4'd1: v = RECIP_W'(1398);
         4'd2: v = RECIP_W'(2097);
         4'd3: v = RECIP_W'(3043);
         4'd4: v = RECIP_W'(2796);
         4'd5: v = RECIP_W'(4194);
         4'd6: v = RECIP_W'(6086);
         4'd7: v = RECIP_W'(5592);
         default: v = RECIP_W'(8388);
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/mahd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahd_front - header check and field classification
// Validates one header, decodes layer, rates and side-info size, and forms
// the dividend and reciprocal for the frame length division.
// ----------------------------------------------------------------------------
module mahd_front
   import mahd_pkg::*;
(
   input  req_type   hdr,
   output entry_type entry
);

   logic        hdr_ok;
   logic        lsf;
   logic [3:0]  fidx_raw;
   logic [3:0]  fidx;
   logic [1:0]  layer;
   logic        chan;
   logic [5:0]  side;
   logic [8:0]  br;
   logic [17:0] mul_k;
   logic [26:0] numer_full;

   // Header checks
   assign hdr_ok = (hdr.sync_word == SYNC_PATTERN) &&
                   (hdr.layer_code != LCODE_RESERVED) &&
                   (hdr.bitrate_index != BRI_FREE) &&
                   (hdr.bitrate_index != BRI_BAD) &&
                   (hdr.rate_index != RATE_RESERVED) &&
                   !(hdr.version_id && (hdr.layer_code == LCODE_LAYER1) &&
                     hdr.crc_absent);

   // Version, rate index and layer decode
   always_comb begin
      lsf = ~(hdr.ext_flag & hdr.version_id);
      if (!hdr.ext_flag)
         fidx_raw = {2'b00, hdr.rate_index} + 4'd6;
      else if (lsf)
         fidx_raw = {2'b00, hdr.rate_index} + 4'd3;
      else
         fidx_raw = {2'b00, hdr.rate_index};
      fidx  = (fidx_raw > FIDX_MAX) ? FIDX_MAX : fidx_raw;
      layer = 2'd0 - hdr.layer_code;
      chan  = (hdr.channel_mode != MODE_MONO);
      br    = kbps_lookup(lsf, layer, hdr.bitrate_index);
   end

   // Layer 3 side info and the slot multiplier
   always_comb begin
      side  = 6'd0;
      mul_k = MUL_SLOTS;
      case (layer)
         LAYER_1: mul_k = MUL_LAYER1;
         LAYER_2: mul_k = MUL_SLOTS;
         default: begin
            mul_k = lsf ? MUL_SLOTS_LSF : MUL_SLOTS;
            case ({lsf, chan})
               2'b00:   side = 6'd17;
               2'b01:   side = 6'd32;
               2'b10:   side = 6'd9;
               default: side = 6'd17;
            endcase
            if (!hdr.crc_absent)
               side = side + 6'd2;
         end
      endcase
   end

   // Dividend: kbit/s times slot multiplier (below 2^26)
   assign numer_full = 27'(br) * 27'(mul_k);

   always_comb begin
      entry.info.hdr_ok = hdr_ok;
      entry.info.layer  = layer;
      entry.info.lsf    = lsf;
      entry.info.chan   = chan;
      entry.info.side   = side;
      entry.info.hz     = hz_lookup(fidx);
      entry.info.br     = br;
      entry.info.fidx   = fidx;
      entry.info.pad    = hdr.padding;
      entry.numer       = numer_full[NUMER_W-1:0];
      entry.recip       = recip_lookup(fidx);
   end

endmodule

// ----- rtl/mahd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahd_queue - classified header queue
// Small FIFO between the front and back sections.
// ----------------------------------------------------------------------------
module mahd_queue
   import mahd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type head,
   output logic      not_empty,
   output logic      full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign not_empty = (count_ff != CNT_W'(0));
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = store_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push)
         store_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- rtl/mahd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahd_back - frame length divider and result formatting
// Three-stage pipeline: reciprocal multiply, remainder product, then the
// quotient correction, frame length arithmetic and result register.
// ----------------------------------------------------------------------------
module mahd_back
   import mahd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      entry_valid,
   input  entry_type entry,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   localparam int PROD_W = NUMER_W + RECIP_W;

   // Stage 1: quotient estimate
   logic               s1_valid_ff;
   info_type           s1_info_ff;
   logic [NUMER_W-1:0] s1_numer_ff;
   logic [QUOT_W-1:0]  s1_qest_ff;
   logic [PROD_W-1:0]  recip_prod;

   // Stage 2: estimate times divisor
   logic               s2_valid_ff;
   info_type           s2_info_ff;
   logic [NUMER_W-1:0] s2_numer_ff;
   logic [QUOT_W-1:0]  s2_qest_ff;
   logic [NUMER_W-1:0] s2_back_ff;
   logic [27:0]        back_prod;

   // Stage 3: correction and length
   logic [NUMER_W-1:0] rem;
   logic [QUOT_W-1:0]  quot;
   logic [11:0]        slots;
   logic [11:0]        len;
   rsp_type            rsp_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign recip_prod = PROD_W'(entry.numer) * PROD_W'(entry.recip);
   assign back_prod  = 28'(s1_qest_ff) * 28'(s1_info_ff.hz);

   // Valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= entry_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Data pipeline
   always_ff @(posedge clock) begin
      s1_info_ff  <= entry.info;
      s1_numer_ff <= entry.numer;
      s1_qest_ff  <= recip_prod[RECIP_SHIFT +: QUOT_W];
      s2_info_ff  <= s1_info_ff;
      s2_numer_ff <= s1_numer_ff;
      s2_qest_ff  <= s1_qest_ff;
      s2_back_ff  <= back_prod[NUMER_W-1:0];
      rsp_data_ff <= rsp_in;
   end

   // Estimate is low by at most one: bump when the remainder reaches the divisor
   always_comb begin
      rem   = s2_numer_ff - s2_back_ff;
      quot  = (rem >= NUMER_W'(s2_info_ff.hz)) ? s2_qest_ff + QUOT_W'(1) : s2_qest_ff;
      slots = quot + {11'd0, s2_info_ff.pad};
      case (s2_info_ff.layer)
         LAYER_1: len = {slots[9:0], 2'b00} - 12'd4;
         LAYER_2: len = slots - 12'd4;
         default: len = slots - 12'd4 - {6'd0, s2_info_ff.side};
      endcase
   end

   // Result formatting; a failed header clears every field
   always_comb begin
      rsp_in = '0;
      if (s2_info_ff.hdr_ok) begin
         rsp_in.header_valid     = 1'b1;
         rsp_in.decode_ok        = (len != 12'd0);
         rsp_in.layer_number     = s2_info_ff.layer;
         rsp_in.payload_len      = len;
         rsp_in.low_rate_flag    = s2_info_ff.lsf;
         rsp_in.two_channels     = s2_info_ff.chan;
         rsp_in.side_info_bytes  = s2_info_ff.side;
         rsp_in.sample_rate_hz   = s2_info_ff.hz;
         rsp_in.bitrate_kbps     = s2_info_ff.br;
         rsp_in.rate_table_index = s2_info_ff.fidx;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/mpeg_audio_header_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeg_audio_header_decode - MPEG-1/2/2.5 audio frame header decoder
// Checks one frame header and returns layer, rates, side-info size and
// frame length, one result per accepted header.
// ----------------------------------------------------------------------------
// Usage:
//   A header transaction is taken on a clock edge where start is high and
//   busy is low; req_data carries the header fields. Each header gives
//   exactly one result on rsp_data, marked by rsp_valid for one cycle.
//   The front section checks and classifies the header and forms the
//   divider operands in the accept cycle, writing them into a short queue.
//   The back section pops one entry per cycle into a three-stage pipeline
//   (reciprocal multiply, remainder product, correction and format).
//   An accepted header passes the queue, stage 1, stage 2 and result registers.
//   Throughput: one header per cycle; the back pipeline drains the queue
//   every cycle, so the queue never holds more than one entry and busy
//   stays low when QUEUE_DEPTH is above one.
//   Reset clears the queue and pipeline valid bits; no result is in flight
//   after reset. The receiver cannot stall: results must be taken as shown.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decode
   import mahd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   entry_type front_entry;
   entry_type queue_head;
   logic      queue_not_empty;
   logic      queue_full;

   mahd_front u_front (
      .hdr   (req_data),
      .entry (front_entry)
   );

   mahd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start),
      .push_data (front_entry),
      .pop       (queue_not_empty),
      .head      (queue_head),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   mahd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_not_empty),
      .entry       (queue_head),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign busy = queue_full;

endmodule
